// ===== rtl/lfu_pkg.sv =====
// Shared types and constants of the LFU cache table.
package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 32;
    localparam int STAMP_W = 48;
    localparam int CAP_W   = 5;
    // Slot numbers are carried at a fixed width that covers up to 256 cells.
    localparam int SLOT_W  = 8;

    localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(16);
    localparam logic [VAL_W-1:0]   READ_MISS   = {VAL_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_FIRST = COUNT_W'(1);

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] store_value;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_TOUCH  = 2'd1,
        OP_WRITE  = 2'd2,
        OP_INSERT = 2'd3
    } op_t;

    typedef struct packed {
        logic                match;
        logic [SLOT_W-1:0]   match_idx;
        logic [VAL_W-1:0]    match_value;
        logic                victim_ok;
        logic [SLOT_W-1:0]   victim_idx;
        logic [COUNT_W-1:0]  victim_count;
        logic [STAMP_W-1:0]  victim_stamp;
        logic                free_ok;
        logic [SLOT_W-1:0]   free_idx;
    } scan_t;

    typedef struct packed {
        op_t                 op;
        logic [SLOT_W-1:0]   idx;
        logic [KEY_W-1:0]    key;
        logic [VAL_W-1:0]    value;
        logic [STAMP_W-1:0]  stamp;
    } wr_t;

endpackage

// ===== rtl/lfu_cell.sv =====
// One cache entry that updates the passing scan record and applies write commands.
module lfu_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lfu_pkg::KEY_W-1:0]  key,
    input  logic                       tok_in_valid,
    input  lfu_pkg::scan_t             tok_in,
    output logic                       tok_out_valid,
    output lfu_pkg::scan_t             tok_out,
    input  lfu_pkg::wr_t               wr
);

    localparam logic [lfu_pkg::SLOT_W-1:0] MY_IDX = lfu_pkg::SLOT_W'(CELL_IDX);

    logic                          valid_reg;
    logic                          valid_next;
    logic [lfu_pkg::KEY_W-1:0]     key_reg;
    logic [lfu_pkg::KEY_W-1:0]     key_next;
    logic [lfu_pkg::VAL_W-1:0]     value_reg;
    logic [lfu_pkg::VAL_W-1:0]     value_next;
    logic [lfu_pkg::COUNT_W-1:0]   count_reg;
    logic [lfu_pkg::COUNT_W-1:0]   count_next;
    logic [lfu_pkg::STAMP_W-1:0]   stamp_reg;
    logic [lfu_pkg::STAMP_W-1:0]   stamp_next;
    logic                          tok_valid_reg;
    lfu_pkg::scan_t                tok_reg;
    lfu_pkg::scan_t                tok_next;
    logic                          sel;
    logic [lfu_pkg::COUNT_W-1:0]   count_inc;

    always_comb
    begin
        tok_next = tok_in;
        if (valid_reg)
        begin
            if (!tok_in.match && key_reg == key)
            begin
                tok_next.match       = 1'b1;
                tok_next.match_idx   = MY_IDX;
                tok_next.match_value = value_reg;
            end
            if (!tok_in.victim_ok || count_reg < tok_in.victim_count ||
                (count_reg == tok_in.victim_count && stamp_reg < tok_in.victim_stamp))
            begin
                tok_next.victim_ok    = 1'b1;
                tok_next.victim_idx   = MY_IDX;
                tok_next.victim_count = count_reg;
                tok_next.victim_stamp = stamp_reg;
            end
        end
        else if (!tok_in.free_ok)
        begin
            tok_next.free_ok  = 1'b1;
            tok_next.free_idx = MY_IDX;
        end
    end

    assign sel       = (wr.idx == MY_IDX);
    assign count_inc = (count_reg == {lfu_pkg::COUNT_W{1'b1}}) ? count_reg
                                                               : count_reg + 1'b1;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        count_next = count_reg;
        stamp_next = stamp_reg;
        if (sel)
        begin
            case (wr.op)
                lfu_pkg::OP_NONE:
                begin
                end
                lfu_pkg::OP_TOUCH:
                begin
                    count_next = count_inc;
                    stamp_next = wr.stamp;
                end
                lfu_pkg::OP_WRITE:
                begin
                    value_next = wr.value;
                    count_next = count_inc;
                    stamp_next = wr.stamp;
                end
                lfu_pkg::OP_INSERT:
                begin
                    valid_next = 1'b1;
                    key_next   = wr.key;
                    value_next = wr.value;
                    count_next = lfu_pkg::COUNT_FIRST;
                    stamp_next = wr.stamp;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            tok_valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        count_reg <= count_next;
        stamp_reg <= stamp_next;
        tok_reg   <= tok_next;
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

// ===== rtl/lfu_cache_table.sv =====
// Top level of the LFU cache table: request control, entry chain and write-back.
//
// Usage: an item (get or put of a key) is taken at a clock edge with start high
// and busy low. Each item gives exactly one result on rsp, shown for one cycle
// with done high; the receiver cannot stall, so results are never held back.
// The item is registered together with a launch flag, and the scan record then
// moves through the row of entry cells one cell per cycle to find the key, the
// lowest-count and oldest entry and the first free slot. When the record leaves
// the last cell, the result and the write command for the chosen cell are
// registered; the cell takes the command at the edge at which busy falls. A new
// item is taken only after busy falls, so one item is finished before the next.
// With a capacity of zero the scan is skipped and the result is shown in the
// cycle after the item is taken.
// The capacity register is written through cfg_valid/cfg_ready/cfg_data while
// busy is low. Reset clears all entry valid bits, the occupancy and the access
// clock, and sets the capacity to 16; no clearing pass is needed.
module lfu_cache_table #(
    parameter int ENTRIES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  lfu_pkg::req_t               req,
    output logic                        done,
    output lfu_pkg::rsp_t               rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]   cfg_data
);

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    lfu_pkg::req_t                 req_reg;
    lfu_pkg::req_t                 req_next;
    logic                          launch_reg;
    logic                          launch_next;
    logic [lfu_pkg::CAP_W-1:0]     cap_reg;
    logic [lfu_pkg::CAP_W-1:0]     cap_next;
    logic [OCC_W-1:0]              occ_reg;
    logic [OCC_W-1:0]              occ_next;
    logic [lfu_pkg::STAMP_W-1:0]   clock_reg;
    logic [lfu_pkg::STAMP_W-1:0]   clock_next;
    lfu_pkg::wr_t                  wr_reg;
    lfu_pkg::wr_t                  wr_next;
    lfu_pkg::rsp_t                 rsp_reg;
    lfu_pkg::rsp_t                 rsp_next;

    logic                          tok_v [0:ENTRIES];
    lfu_pkg::scan_t                tok   [0:ENTRIES];
    lfu_pkg::scan_t                last;
    logic [CMP_W-1:0]              cap_ext;
    logic [CMP_W-1:0]              cap_eff;
    logic                          full;

    assign tok_v[0] = launch_reg;
    assign tok[0]   = '0;
    assign last     = tok[ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            lfu_cell #(
                .CELL_IDX(gi)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .key           (req_reg.lookup_key),
                .tok_in_valid  (tok_v[gi]),
                .tok_in        (tok[gi]),
                .tok_out_valid (tok_v[gi+1]),
                .tok_out       (tok[gi+1]),
                .wr            (wr_reg)
            );
        end
    endgenerate

    assign cap_ext = CMP_W'(cap_reg);
    assign cap_eff = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    assign full    = (CMP_W'(occ_reg) >= cap_eff);

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done      = (state_reg == ST_DONE);
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        launch_next = 1'b0;
        cap_next    = cap_reg;
        occ_next    = occ_reg;
        clock_next  = clock_reg;
        wr_next     = wr_reg;
        rsp_next    = rsp_reg;
        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_data;
        end
        case (state_reg)
            ST_IDLE:
            begin
                wr_next.op = lfu_pkg::OP_NONE;
                if (start)
                begin
                    req_next = req;
                    if (cap_reg == '0)
                    begin
                        rsp_next.hit        = 1'b0;
                        rsp_next.read_value = req.req_type ? '0 : lfu_pkg::READ_MISS;
                        rsp_next.evicted    = 1'b0;
                        state_next          = ST_DONE;
                    end
                    else
                    begin
                        launch_next = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (tok_v[ENTRIES])
                begin
                    wr_next.key   = req_reg.lookup_key;
                    wr_next.value = req_reg.store_value;
                    wr_next.stamp = clock_reg;
                    wr_next.idx   = last.match_idx;
                    rsp_next      = '0;
                    if (!req_reg.req_type)
                    begin
                        if (last.match)
                        begin
                            wr_next.op          = lfu_pkg::OP_TOUCH;
                            rsp_next.hit        = 1'b1;
                            rsp_next.read_value = last.match_value;
                        end
                        else
                        begin
                            wr_next.op          = lfu_pkg::OP_NONE;
                            rsp_next.read_value = lfu_pkg::READ_MISS;
                        end
                    end
                    else if (last.match)
                    begin
                        wr_next.op   = lfu_pkg::OP_WRITE;
                        rsp_next.hit = 1'b1;
                    end
                    else
                    begin
                        wr_next.op = lfu_pkg::OP_INSERT;
                        if (full && last.victim_ok)
                        begin
                            wr_next.idx      = last.victim_idx;
                            rsp_next.evicted = 1'b1;
                        end
                        else
                        begin
                            wr_next.idx = last.free_idx;
                        end
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (wr_reg.op != lfu_pkg::OP_NONE)
                begin
                    clock_next = clock_reg + 1'b1;
                end
                if (wr_reg.op == lfu_pkg::OP_INSERT && !rsp_reg.evicted)
                begin
                    occ_next = occ_reg + 1'b1;
                end
                wr_next.op = lfu_pkg::OP_NONE;
                state_next = ST_IDLE;
            end
            default:
            begin
                wr_next.op = lfu_pkg::OP_NONE;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
            cap_reg    <= lfu_pkg::CAP_RESET;
            occ_reg    <= '0;
            clock_reg  <= '0;
            wr_reg     <= '{op: lfu_pkg::OP_NONE, default: '0};
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            cap_reg    <= cap_next;
            occ_reg    <= occ_next;
            clock_reg  <= clock_next;
            wr_reg     <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        rsp_reg       <= rsp_next;
    end

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result shown without an item in progress");

    a_scan_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_v[ENTRIES] |-> state_reg == ST_SCAN)
        else $error("scan record left the chain outside the scan state");

    a_write_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg.op != lfu_pkg::OP_NONE |-> state_reg == ST_DONE)
        else $error("entry write command outside the write-back cycle");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(occ_reg) <= CMP_W'(ENTRIES))
        else $error("occupancy exceeds the number of entries");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the LFU cache table with a shadow cache scoreboard.
`timescale 1ns / 100ps

localparam int SLOTS = 16;
localparam logic REQ_GET = 1'b0;
localparam logic REQ_PUT = 1'b1;

class cache_shadow;
    logic [lfu_pkg::CAP_W-1:0]   capacity;
    logic                        valid [SLOTS];
    logic [lfu_pkg::KEY_W-1:0]   keys [SLOTS];
    logic [lfu_pkg::VAL_W-1:0]   values [SLOTS];
    logic [lfu_pkg::COUNT_W-1:0] counts [SLOTS];
    logic [lfu_pkg::STAMP_W-1:0] stamps [SLOTS];
    logic [lfu_pkg::STAMP_W-1:0] access_clock;
    lfu_pkg::rsp_t               expected_rsps [$];
    int                          mismatch_count;

    function new();
        capacity = lfu_pkg::CAP_RESET;
        access_clock = '0;
        mismatch_count = 0;
        foreach (valid[i])
        begin
            valid[i] = 1'b0;
            keys[i] = '0;
            values[i] = '0;
            counts[i] = '0;
            stamps[i] = '0;
        end
    endfunction

    function void touch(int slot);
        if (counts[slot] != '1)
            counts[slot] = counts[slot] + 1'b1;
        stamps[slot] = access_clock;
        access_clock = access_clock + 1'b1;
    endfunction

    function lfu_pkg::rsp_t predict_response(lfu_pkg::req_t item);
        lfu_pkg::rsp_t rsp;
        int   limit;
        int   match;
        int   free_slot;
        int   victim;
        int   used;
        rsp = '0;
        match = -1;
        free_slot = -1;
        victim = -1;
        used = 0;
        limit = (capacity > SLOTS) ? SLOTS : int'(capacity);
        if (limit == 0)
        begin
            if (item.req_type == REQ_GET)
                rsp.read_value = lfu_pkg::READ_MISS;
            return rsp;
        end
        for (int i = 0; i < SLOTS; i++)
            if (valid[i] && keys[i] == item.lookup_key && match < 0)
                match = i;
        if (item.req_type == REQ_GET)
        begin
            if (match < 0)
                rsp.read_value = lfu_pkg::READ_MISS;
            else
            begin
                touch(match);
                rsp.hit = 1'b1;
                rsp.read_value = values[match];
            end
            return rsp;
        end
        if (match >= 0)
        begin
            values[match] = item.store_value;
            touch(match);
            rsp.hit = 1'b1;
            return rsp;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (valid[i])
            begin
                used++;
                if (victim < 0 || counts[i] < counts[victim] ||
                    (counts[i] == counts[victim] && stamps[i] < stamps[victim]))
                    victim = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        if (used >= limit && victim >= 0)
        begin
            free_slot = victim;
            rsp.evicted = 1'b1;
        end
        if (free_slot >= 0)
        begin
            valid[free_slot] = 1'b1;
            keys[free_slot] = item.lookup_key;
            values[free_slot] = item.store_value;
            counts[free_slot] = lfu_pkg::COUNT_FIRST;
            stamps[free_slot] = access_clock;
            access_clock = access_clock + 1'b1;
        end
        return rsp;
    endfunction

    function void note_request(lfu_pkg::req_t item);
        expected_rsps.push_back(predict_response(item));
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    task check_response(lfu_pkg::rsp_t got);
        lfu_pkg::rsp_t want;
        if (expected_rsps.size() == 0)
        begin
            report($sformatf("result with nothing expected: hit %b value %h evicted %b",
                             got.hit, got.read_value, got.evicted));
            return;
        end
        want = expected_rsps.pop_front();
        if (got.hit !== want.hit)
            report($sformatf("hit is %b, expected %b", got.hit, want.hit));
        if (got.read_value !== want.read_value)
            report($sformatf("read_value is %h, expected %h", got.read_value,
                             want.read_value));
        if (got.evicted !== want.evicted)
            report($sformatf("evicted is %b, expected %b", got.evicted, want.evicted));
    endtask

    task close();
        if (expected_rsps.size() != 0)
            report($sformatf("%0d results never arrived", expected_rsps.size()));
    endtask
endclass

module testbench;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int POOL_SIZE = 24;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    lfu_pkg::req_t             req = '0;
    logic                      cfg_valid = 1'b0;
    logic [lfu_pkg::CAP_W-1:0] cfg_data = '0;
    logic                      busy;
    logic                      done;
    lfu_pkg::rsp_t             rsp;
    logic                      cfg_ready;

    int unsigned               cycle_count = 0;
    int                        burst_left = 0;
    logic [lfu_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    logic [lfu_pkg::CAP_W-1:0] cap_plan [10] = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31,
                                                 5'd7, 5'd2, 5'd16, 5'd5, 5'd12};
    cache_shadow               shadow;

    lfu_cache_table #(
        .ENTRIES(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .rsp(rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
        if (rst_n && done === 1'b1)
            shadow.check_response(rsp);

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic lfu_pkg::req_t make_item(logic kind, logic [31:0] key,
                                                logic [31:0] value);
        lfu_pkg::req_t item;
        item.req_type = kind;
        item.lookup_key = key;
        item.store_value = value;
        return item;
    endfunction

    task automatic send_item(lfu_pkg::req_t item);
        start <= 1'b1;
        req <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shadow.note_request(item);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (shadow.expected_rsps.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [lfu_pkg::CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow.capacity = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic pace();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 1))
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 30))
                    @(posedge clk);
            end
        end
        burst_left--;
    endtask

    function automatic lfu_pkg::req_t random_item(int span);
        lfu_pkg::req_t item;
        item.req_type = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 11) == 0)
            item.lookup_key = $urandom;
        else
            item.lookup_key = key_pool[$urandom_range(0, span - 1)];
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 3))
                0: item.store_value = 32'h8000_0000;
                1: item.store_value = 32'h7FFF_FFFF;
                2: item.store_value = 32'h0;
                default: item.store_value = 32'hFFFF_FFFF;
            endcase
        end
        else
            item.store_value = $urandom;
        return item;
    endfunction

    task automatic random_phase(logic [lfu_pkg::CAP_W-1:0] cap, int count);
        int span;
        drain();
        write_capacity(cap);
        foreach (key_pool[i])
            if ($urandom_range(0, 1))
                key_pool[i] = $urandom;
        span = ((cap > SLOTS) ? SLOTS : int'(cap)) + $urandom_range(1, 8);
        if (span > POOL_SIZE)
            span = POOL_SIZE;
        repeat (count)
        begin
            pace();
            send_item(random_item(span));
            if ($urandom_range(0, 99) == 0)
                drain();
        end
    endtask

    initial
    begin
        shadow = new();
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_capacity(5'd16);

        // Empty cache, extreme keys and values, put and get hits, update in place.
        send_item(make_item(REQ_GET, 32'h0, 32'h0));
        send_item(make_item(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(make_item(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_item(REQ_PUT, 32'h0, 32'hFFFF_FFFF));
        send_item(make_item(REQ_PUT, 32'hFFFF_FFFF, 32'h0));
        send_item(make_item(REQ_GET, 32'h8000_0000, 32'h0));
        send_item(make_item(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(REQ_PUT, 32'h0, 32'h1234_5678));
        send_item(make_item(REQ_GET, 32'h0, 32'h0));
        send_item(make_item(REQ_GET, 32'h5, 32'h0));

        // A full cache evicts the least used entry, then the newest one.
        drain();
        write_capacity(5'd4);
        send_item(make_item(REQ_PUT, 32'd100, 32'hA5A5_A5A5));
        send_item(make_item(REQ_PUT, 32'd101, 32'h5A5A_5A5A));

        // Capacity below occupancy keeps the entries but evicts on every insert.
        drain();
        write_capacity(5'd2);
        send_item(make_item(REQ_PUT, 32'd200, 32'h0000_0200));
        send_item(make_item(REQ_GET, 32'd200, 32'h0));
        send_item(make_item(REQ_PUT, 32'd201, 32'h0000_0201));

        // A disabled cache misses on every get and ignores every put.
        drain();
        write_capacity(5'd0);
        send_item(make_item(REQ_GET, 32'hFFFF_FFFF, 32'h0));
        send_item(make_item(REQ_PUT, 32'd300, 32'h0000_0300));
        send_item(make_item(REQ_GET, 32'd201, 32'h0));

        // Capacity above the table size acts as the full table.
        drain();
        write_capacity(5'd31);
        send_item(make_item(REQ_PUT, 32'd400, 32'h0000_0400));
        send_item(make_item(REQ_GET, 32'd400, 32'h0));

        foreach (cap_plan[i])
        begin
            if (i >= 8)
                random_phase(5'($urandom_range(0, 31)), 110);
            else
                random_phase(cap_plan[i], 110);
        end

        drain();
        repeat (SLOTS + 4)
            @(posedge clk);
        shadow.close();
        if (shadow.mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
